FILE: rtl/sclm_pkg.sv
`timescale 1ns / 1ps

package sclm_pkg;

  // Block geometry
  localparam int unsigned BINS_PER_COLUMN = 13;
  localparam int unsigned COLUMNS         = 23;
  localparam int unsigned ROWS            = 6;

  // Fixed keyboard layout
  localparam int unsigned TABLE_COLS = 23;
  localparam int unsigned OUT_ROWS   = 6;
  localparam logic [6:0]  NO_LED     = 7'd127;
  localparam logic [6:0]  LINKED_LED = 7'd11;
  localparam int unsigned FULL_SCALE = 255;

  // Internal widths
  localparam int unsigned BIN_W  = $clog2(BINS_PER_COLUMN + 1);
  localparam int unsigned COL_W  = $clog2(COLUMNS + 1);
  localparam int unsigned LVL_W  = $clog2(ROWS + 1);
  localparam int unsigned TIDX_W = $clog2(TABLE_COLS);

  // Configuration registers
  localparam int unsigned ADDR_W       = 2;
  localparam logic [7:0]  GAIN_RESET   = 8'd13;
  localparam int unsigned REG_PEAK_GAIN = 0;

  typedef struct packed {
    logic [7:0] bin_value;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [4:0] column_index;
    logic [2:0] bar_level;
    logic [6:0] led_row0;
    logic [6:0] led_row1;
    logic [6:0] led_row2;
    logic [6:0] led_row3;
    logic [6:0] led_row4;
    logic [6:0] led_row5;
    logic       extra_led_on;
    logic       frame_done;
  } out_item_t;

  // LED number per column and row, row 0 at the bottom
  localparam logic [6:0] LED_MAP [TABLE_COLS][OUT_ROWS] = '{
    '{7'd96,  7'd77,  7'd60,  7'd38,  7'd16,  7'd127},
    '{7'd97,  7'd78,  7'd61,  7'd39,  7'd17,  7'd0  },
    '{7'd98,  7'd79,  7'd62,  7'd40,  7'd18,  7'd127},
    '{7'd99,  7'd80,  7'd63,  7'd41,  7'd19,  7'd1  },
    '{7'd100, 7'd81,  7'd64,  7'd42,  7'd20,  7'd2  },
    '{7'd127, 7'd82,  7'd65,  7'd43,  7'd21,  7'd3  },
    '{7'd127, 7'd83,  7'd66,  7'd44,  7'd22,  7'd4  },
    '{7'd127, 7'd84,  7'd67,  7'd45,  7'd23,  7'd127},
    '{7'd127, 7'd85,  7'd68,  7'd46,  7'd24,  7'd5  },
    '{7'd127, 7'd86,  7'd69,  7'd47,  7'd25,  7'd6  },
    '{7'd127, 7'd87,  7'd70,  7'd48,  7'd26,  7'd7  },
    '{7'd101, 7'd88,  7'd71,  7'd49,  7'd27,  7'd8  },
    '{7'd102, 7'd89,  7'd72,  7'd50,  7'd28,  7'd9  },
    '{7'd103, 7'd90,  7'd73,  7'd51,  7'd29,  7'd10 },
    '{7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd11 },
    '{7'd104, 7'd127, 7'd52,  7'd127, 7'd30,  7'd12 },
    '{7'd105, 7'd127, 7'd127, 7'd53,  7'd31,  7'd13 },
    '{7'd106, 7'd91,  7'd127, 7'd54,  7'd32,  7'd14 },
    '{7'd107, 7'd127, 7'd127, 7'd55,  7'd33,  7'd15 },
    '{7'd108, 7'd92,  7'd74,  7'd56,  7'd34,  7'd127},
    '{7'd127, 7'd93,  7'd75,  7'd57,  7'd35,  7'd127},
    '{7'd109, 7'd94,  7'd76,  7'd58,  7'd36,  7'd127},
    '{7'd95,  7'd127, 7'd59,  7'd127, 7'd37,  7'd127}
  };

endpackage

FILE: rtl/spectrum_column_led_meter.sv
`timescale 1ns / 1ps

// Spectrum column LED meter.
// Input channel (in_valid_i/in_ready_o, in_data_i): one spectrum bin per item;
// frame_start marks the first bin of a frame and restarts the column count.
// Every 13th bin of a frame closes a column; after 23 columns bins are
// dropped until the next frame start. Each closed column gives one item on
// the output channel (out_valid_o/out_ready_i, out_data_o): column index, bar
// level, LED number of each of the six rows and the LED 11 companion flag.
// peak_gain is written through the APB port; the decode compares paddr >> 2
// with 0, so every address selects it (reset value 13). Throughput: one bin
// per cycle while in_ready_o is high. A closed column passes from the closing
// stage, loaded at the edge that accepts its last bin, to the output register,
// loaded from the gain multiply / level / LED lookup stage.
// When the receiver stalls, the result holds and the closing stage can hold
// one more column; input stalls only once both stages are full.
// Reset clears the pipeline valids, bin and peak counters, sets the column
// count to idle (no results until a frame start) and loads gain 13.
module spectrum_column_led_meter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sclm_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sclm_pkg::out_item_t       out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sclm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [7:0] gain_q;

  logic [sclm_pkg::BIN_W-1:0] bin_cnt_q, bin_cnt_d;
  logic [sclm_pkg::COL_W-1:0] col_cnt_q, col_cnt_d;
  logic [7:0]                 peak_q, peak_d;

  logic                       cls_valid_q;
  logic [7:0]                 cls_peak_q;
  logic [sclm_pkg::COL_W-1:0] cls_col_q;

  logic                       out_valid_q;
  sclm_pkg::out_item_t        out_q, out_d;

  logic in_acc, out_adv, cls_adv, closing;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {24'd0, gain_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= sclm_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite &&
                 (paddr >> 2) == sclm_pkg::ADDR_W'(sclm_pkg::REG_PEAK_GAIN)) begin
      gain_q <= pwdata[7:0];
    end
  end

  // Handshake: output register frees on take, closing stage moves on behind it
  assign out_adv    = !out_valid_q || out_ready_i;
  assign cls_adv    = !cls_valid_q || out_adv;
  assign in_ready_o = cls_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Bin accumulation and column closing
  always_comb begin
    logic [sclm_pkg::BIN_W-1:0] b;
    logic [sclm_pkg::COL_W-1:0] c;
    logic [7:0]                 p;
    b = in_data_i.frame_start ? '0 : bin_cnt_q;
    c = in_data_i.frame_start ? '0 : col_cnt_q;
    p = in_data_i.frame_start ? '0 : peak_q;
    bin_cnt_d = bin_cnt_q;
    col_cnt_d = col_cnt_q;
    peak_d    = peak_q;
    closing   = 1'b0;
    if (c < sclm_pkg::COL_W'(sclm_pkg::COLUMNS)) begin
      if (in_data_i.bin_value > p) begin
        p = in_data_i.bin_value;
      end
      b = b + 1'b1;
      if (b == sclm_pkg::BIN_W'(sclm_pkg::BINS_PER_COLUMN)) begin
        closing   = 1'b1;
        bin_cnt_d = '0;
        col_cnt_d = c + 1'b1;
        peak_d    = p;
      end else begin
        bin_cnt_d = b;
        col_cnt_d = c;
        peak_d    = p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q   <= '0;
      col_cnt_q   <= sclm_pkg::COL_W'(sclm_pkg::COLUMNS);
      peak_q      <= '0;
      cls_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        bin_cnt_q <= bin_cnt_d;
        col_cnt_q <= col_cnt_d;
        peak_q    <= closing ? 8'd0 : peak_d;
      end
      if (cls_adv) begin
        cls_valid_q <= in_acc && closing;
      end
    end
  end

  // Closed column payload
  always_ff @(posedge clk_i) begin
    if (in_acc && closing) begin
      cls_peak_q <= peak_d;
      cls_col_q  <= col_cnt_d - 1'b1;
    end
  end

  // Gain, saturation, level and LED lookup
  always_comb begin
    logic [15:0]                 prod;
    logic [7:0]                  scaled;
    logic [sclm_pkg::LVL_W-1:0]  level;
    logic [6:0]                  led [sclm_pkg::OUT_ROWS];
    logic                        extra;
    logic                        in_table;
    logic [sclm_pkg::TIDX_W-1:0] tidx;
    prod   = 16'(cls_peak_q) * 16'(gain_q);
    scaled = (prod[15:8] != 8'd0) ? 8'hFF : prod[7:0];
    level  = '0;
    for (int k = 1; k <= sclm_pkg::ROWS; k++) begin
      if (16'(scaled) * 16'(sclm_pkg::ROWS) >= 16'(sclm_pkg::FULL_SCALE * k)) begin
        level = sclm_pkg::LVL_W'(k);
      end
    end
    in_table = cls_col_q < sclm_pkg::COL_W'(sclm_pkg::TABLE_COLS);
    tidx     = in_table ? sclm_pkg::TIDX_W'(cls_col_q) : '0;
    extra    = 1'b0;
    for (int r = 0; r < sclm_pkg::OUT_ROWS; r++) begin
      led[r] = sclm_pkg::NO_LED;
      if (32'(level) > r && in_table) begin
        led[r] = sclm_pkg::LED_MAP[tidx][r];
      end
      if (led[r] == sclm_pkg::LINKED_LED) begin
        extra = 1'b1;
      end
    end
    out_d.column_index = 5'(cls_col_q);
    out_d.bar_level    = 3'(level);
    out_d.led_row0     = led[0];
    out_d.led_row1     = led[1];
    out_d.led_row2     = led[2];
    out_d.led_row3     = led[3];
    out_d.led_row4     = led[4];
    out_d.led_row5     = led[5];
    out_d.extra_led_on = extra;
    out_d.frame_done   = cls_col_q == sclm_pkg::COL_W'(sclm_pkg::COLUMNS - 1);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= cls_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && cls_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_cnt_q <= sclm_pkg::COL_W'(sclm_pkg::COLUMNS))
    else $error("column counter past frame end");

  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_cnt_q < sclm_pkg::BIN_W'(sclm_pkg::BINS_PER_COLUMN))
    else $error("bin counter past column size");

  a_cls_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_valid_q && !out_adv |=> cls_valid_q && $stable(cls_peak_q) && $stable(cls_col_q))
    else $error("closed column lost while output stalled");

  a_extra_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.extra_led_on |->
      (out_data_o.led_row0 == sclm_pkg::LINKED_LED ||
       out_data_o.led_row1 == sclm_pkg::LINKED_LED ||
       out_data_o.led_row2 == sclm_pkg::LINKED_LED ||
       out_data_o.led_row3 == sclm_pkg::LINKED_LED ||
       out_data_o.led_row4 == sclm_pkg::LINKED_LED ||
       out_data_o.led_row5 == sclm_pkg::LINKED_LED))
    else $error("companion LED flagged without LED 11 lit");

endmodule
